[hdl/wss_pkg.sv]
package wss_pkg;

	localparam int unsigned MAX_ITEMS_DEF = 16;
	localparam int unsigned TOTAL_W = 21;
	localparam int unsigned DRAW_W = 16;
	localparam logic [31:0] HASH_SEED = 32'd1315423911;
	localparam logic [31:0] HASH_X0 = 32'd231232;
	localparam logic [31:0] HASH_Y0 = 32'd1232;
	localparam logic [4:0] ITEM_COUNT_RST = 5'd10;
	localparam logic [31:0] HASH_TAG_RST = 32'd3;

	localparam logic REG_ITEM_COUNT = 1'b0;
	localparam logic REG_HASH_TAG = 1'b1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	// one step of the mix: x = (x - y - z) ^ shift(z)
	// shift amounts and directions for the nine steps of one mix
	function automatic logic [31:0] mix_shift(input logic [3:0] idx, input logic [31:0] v);
		logic [31:0] r;
		r = '0;
		case (idx)
			4'd0: r = v >> 13;
			4'd1: r = v << 8;
			4'd2: r = v >> 13;
			4'd3: r = v >> 12;
			4'd4: r = v << 16;
			4'd5: r = v >> 5;
			4'd6: r = v >> 3;
			4'd7: r = v << 10;
			4'd8: r = v >> 15;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hdl/weighted_straw_select.sv]
// weighted_straw_select: straw-style weighted choice over a table of items.
// Slave channel s_axis_*: one beat is either a slot write (tuser = 0) or a
// selection (tuser = 1). A write stores id and weight into a slot and updates
// the running weight total; it produces no output beat. A selection walks
// slots 0..item_count-1; for each slot one shared 32-bit subtract/xor unit
// runs the 45 steps of the five rjenkins1 mixes, then one restoring divider
// produces floor(draw*weight/total) in 32 steps. The largest draw wins, the
// earliest slot on ties. Master channel m_axis_*: one beat per selection.
// A write leaves the block idle, so the next beat is taken right after.
// A selection runs per slot a load, 45 mix steps, a multiply, 32 divide
// steps and a compare, one step per cycle, and then presents its result.
// A zero-total selection goes straight from idle to the result beat.
// An item_count of 0 walks slot 0; a count above MAX_ITEMS walks MAX_ITEMS slots.
// s_axis_tready is low while an item is in work or the result beat waits.
// A stalled receiver holds the result in the output register; the block
// accepts no new beat until it is taken.
// Reset (arst_n low) clears the table to zero, the total to zero, item_count
// to 10 and hash_tag to 3. A zero total returns no_weight with zero fields.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle; the block itself does not enforce it.
module weighted_straw_select #(
	parameter int unsigned MAX_ITEMS = wss_pkg::MAX_ITEMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: slot[3:0], item_id[35:4], item_weight[51:36], group_id[83:52], zero pad
	input  logic [87:0] s_axis_tdata,
	// tuser: opcode
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: chosen_item[31:0], best_draw[47:32], no_weight[48], zero pad
	output logic [55:0] m_axis_tdata
);

	localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned TW = wss_pkg::TOTAL_W;
	localparam int unsigned PW = 32;   // draw * weight product width
	localparam int unsigned RW = TW + 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_MIX   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_CMP   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// slot table and configuration
	logic [31:0]       ids_q [MAX_ITEMS];
	logic [15:0]       wts_q [MAX_ITEMS];
	logic [TW-1:0]     total_q;
	logic [4:0]        item_count_q;
	logic [31:0]       hash_tag_q;

	// selection working registers
	logic [31:0]       group_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     n_q;
	logic [31:0]       ra_q, rb_q, rc_q, rh_q, rx_q, ry_q;
	logic [2:0]        mix_q;   // which of the five mixes
	logic [3:0]        step_q;  // step within a mix
	logic [PW-1:0]     prod_q;
	logic [RW-1:0]     rem_q;
	logic [5:0]        bit_q;
	logic [15:0]       best_q;
	logic [31:0]       best_id_q;
	logic              first_q;
	logic [55:0]       out_q;

	// beat fields
	logic [3:0]  in_slot;
	logic [31:0] in_id, in_group;
	logic [15:0] in_wt;
	logic [IW-1:0] wr_idx;
	assign in_slot  = s_axis_tdata[3:0];
	assign in_id    = s_axis_tdata[35:4];
	assign in_wt    = s_axis_tdata[51:36];
	assign in_group = s_axis_tdata[83:52];
	assign wr_idx   = IW'(in_slot);

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = out_q;

	// mix operand routing: the three words of the current mix, as in hash3
	logic [31:0] m0, m1, m2, sx, sy, sz, snew;
	always_comb begin
		m0 = ra_q; m1 = rb_q; m2 = rh_q;
		case (mix_q)
			3'd0: begin m0 = ra_q; m1 = rb_q; m2 = rh_q; end
			3'd1: begin m0 = rc_q; m1 = rx_q; m2 = rh_q; end
			3'd2: begin m0 = ry_q; m1 = ra_q; m2 = rh_q; end
			3'd3: begin m0 = rb_q; m1 = rx_q; m2 = rh_q; end
			3'd4: begin m0 = ry_q; m1 = rc_q; m2 = rh_q; end
			default: begin m0 = ra_q; m1 = rb_q; m2 = rh_q; end
		endcase
		// step k updates word k%3 from the next two words in rotation
		case (step_q)
			4'd0, 4'd3, 4'd6: begin sx = m0; sy = m1; sz = m2; end
			4'd1, 4'd4, 4'd7: begin sx = m1; sy = m2; sz = m0; end
			default:          begin sx = m2; sy = m0; sz = m1; end
		endcase
		snew = (sx - sy - sz) ^ wss_pkg::mix_shift(step_q, sz);
	end

	logic [1:0] tgt;
	always_comb begin
		case (step_q)
			4'd0, 4'd3, 4'd6: tgt = 2'd0;
			4'd1, 4'd4, 4'd7: tgt = 2'd1;
			default:          tgt = 2'd2;
		endcase
	end

	// divider trial subtract
	logic [RW-1:0] rem_sh;
	logic [RW:0]   trial;
	assign rem_sh = {rem_q[RW-2:0], prod_q[PW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, total_q};

	logic [PW-1:0] quot;
	assign quot = prod_q;

	logic [15:0] draw_sat;
	assign draw_sat = (quot > PW'(16'hffff)) ? 16'hffff : quot[15:0];

	logic [CW-1:0] n_eff;
	always_comb begin
		if (item_count_q == 5'd0)
			n_eff = CW'(1);
		else if (32'(item_count_q) > MAX_ITEMS)
			n_eff = CW'(MAX_ITEMS);
		else
			n_eff = CW'(item_count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			item_count_q <= wss_pkg::ITEM_COUNT_RST;
			hash_tag_q <= wss_pkg::HASH_TAG_RST;
			for (int i = 0; i < MAX_ITEMS; i++) begin
				ids_q[i] <= '0;
				wts_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == wss_pkg::REG_ITEM_COUNT)
					item_count_q <= cfg_data[4:0];
				else
					hash_tag_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == wss_pkg::OP_WRITE) begin
							if (32'(in_slot) < MAX_ITEMS) begin
								total_q <= total_q - TW'(wts_q[wr_idx]) + TW'(in_wt);
								wts_q[wr_idx] <= in_wt;
								ids_q[wr_idx] <= in_id;
							end
						end else if (total_q == '0) begin
							out_q <= {7'd0, 1'b1, 48'd0};
							state_q <= ST_OUT;
						end else begin
							group_q <= in_group;
							n_q <= n_eff;
							idx_q <= '0;
							first_q <= 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					// hash3(group, id, tag): a=group, b=id, c=tag
					ra_q <= group_q;
					rb_q <= ids_q[idx_q];
					rc_q <= hash_tag_q;
					rh_q <= wss_pkg::HASH_SEED ^ group_q ^ ids_q[idx_q] ^ hash_tag_q;
					rx_q <= wss_pkg::HASH_X0;
					ry_q <= wss_pkg::HASH_Y0;
					mix_q <= '0;
					step_q <= '0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					// write back into the register behind the routed word
					if (tgt == 2'd2) begin
						rh_q <= snew;
					end else begin
						case (mix_q)
							3'd0: if (tgt == 2'd0) ra_q <= snew; else rb_q <= snew;
							3'd1: if (tgt == 2'd0) rc_q <= snew; else rx_q <= snew;
							3'd2: if (tgt == 2'd0) ry_q <= snew; else ra_q <= snew;
							3'd3: if (tgt == 2'd0) rb_q <= snew; else rx_q <= snew;
							3'd4: if (tgt == 2'd0) ry_q <= snew; else rc_q <= snew;
							default: ;
						endcase
					end
					if (step_q == 4'd8) begin
						step_q <= '0;
						if (mix_q == 3'd4)
							state_q <= ST_MUL;
						else
							mix_q <= mix_q + 3'd1;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_MUL: begin
					prod_q <= PW'(rh_q[15:0]) * PW'(wts_q[idx_q]);
					rem_q <= '0;
					bit_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring division, quotient bits shift into prod_q
					if (!trial[RW]) begin
						rem_q <= trial[RW-1:0];
						prod_q <= {prod_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						prod_q <= {prod_q[PW-2:0], 1'b0};
					end
					if (bit_q == 6'(PW - 1))
						state_q <= ST_CMP;
					bit_q <= bit_q + 6'd1;
				end
				ST_CMP: begin
					if (first_q || draw_sat > best_q) begin
						best_q <= draw_sat;
						best_id_q <= ids_q[idx_q];
					end
					first_q <= 1'b0;
					if (32'(idx_q) + 32'd1 >= 32'(n_q)) begin
						state_q <= ST_OUT;
						if (first_q || draw_sat > best_q)
							out_q <= {7'd0, 1'b0, draw_sat, ids_q[idx_q]};
						else
							out_q <= {7'd0, 1'b0, best_q, best_id_q};
					end else begin
						idx_q <= idx_q + IW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (m_axis_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a result beat always follows compare or an idle zero-total select
	a_out_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_CMP || $past(state_q) == ST_IDLE))
		else $error("result beat from unexpected state");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> $past(state_q) == ST_DIV)
		else $error("compare without division");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (CW'(idx_q) < n_q))
		else $error("slot index beyond count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

endmodule
